/* src/mmtc_pkg.sv */
package mmtc_pkg;

	localparam int unsigned TICK_MS_DEF      = 20;
	localparam int unsigned STALL_WINDOW_DEF = 25;

	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_START = 1'b1;

	localparam logic [1:0] MODE_UP    = 2'd0;
	localparam logic [1:0] MODE_DOWN  = 2'd1;
	localparam logic [1:0] MODE_HOME  = 2'd2;
	localparam logic [1:0] MODE_CHECK = 2'd3;

	localparam logic [1:0] DIR_BRAKE = 2'd0;
	localparam logic [1:0] DIR_UP    = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;

	localparam logic ST_OK      = 1'b0;
	localparam logic ST_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_UP    = 2'd1,
		PH_DOWN  = 2'd2,
		PH_CHECK = 2'd3
	} phase_t;

	typedef struct packed {
		logic        req_type;
		logic [1:0]  move_mode;
		logic [15:0] speed;
		logic [31:0] target_steps;
		logic [31:0] timeout_ms;
		logic        top_switch;
		logic        check_switch;
		logic [7:0]  encoder_pulses;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  motor_dir;
		logic [15:0] pwm_speed;
		logic        driver_enable;
		logic        done_res;
		logic        status;
		logic        busy_res;
		logic [31:0] step_count;
	} res_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  active_mode;
		logic [31:0] steps_done;
		logic [31:0] elapsed_ms;
		logic [4:0]  window_ticks;
		logic [31:0] count_snapshot;
		logic [31:0] target_reg;
		logic [31:0] timeout_reg;
		logic [15:0] speed_reg;
	} mstate_t;

endpackage

/* src/mmtc_step.sv */
module mmtc_step #(
	parameter int unsigned TICK_MS      = mmtc_pkg::TICK_MS_DEF,
	parameter int unsigned STALL_WINDOW = mmtc_pkg::STALL_WINDOW_DEF
) (
	input  mmtc_pkg::mstate_t st,
	input  mmtc_pkg::cmd_t    cmd,
	output mmtc_pkg::mstate_t nxt,
	output mmtc_pkg::res_t    res
);

	logic        en;
	logic        done;
	logic        stv;
	logic        run;
	logic        in_time;
	logic        keep;
	logic        s;
	logic [32:0] step_sum;
	logic [32:0] ms_sum;

	always_comb begin
		nxt      = st;
		en       = 1'b0;
		done     = 1'b0;
		stv      = mmtc_pkg::ST_OK;
		run      = 1'b0;
		in_time  = 1'b0;
		keep     = 1'b1;
		s        = mmtc_pkg::ST_OK;
		step_sum = {1'b0, st.steps_done} + 33'(cmd.encoder_pulses);
		ms_sum   = {1'b0, st.elapsed_ms} + 33'(TICK_MS);

		if (cmd.req_type == mmtc_pkg::REQ_START) begin
			if (st.phase == mmtc_pkg::PH_IDLE) begin
				nxt.active_mode = cmd.move_mode;
				nxt.target_reg  = cmd.target_steps;
				nxt.timeout_reg = cmd.timeout_ms;
				if (cmd.move_mode == mmtc_pkg::MODE_UP && cmd.top_switch) begin
					done = 1'b1;
				end else begin
					nxt.speed_reg      = cmd.speed;
					nxt.steps_done     = '0;
					nxt.elapsed_ms     = '0;
					nxt.window_ticks   = '0;
					nxt.count_snapshot = '0;
					en  = 1'b1;
					run = 1'b1;
					if (cmd.move_mode == mmtc_pkg::MODE_UP ||
					    (cmd.move_mode == mmtc_pkg::MODE_HOME && !cmd.top_switch))
						nxt.phase = mmtc_pkg::PH_UP;
					else if (cmd.move_mode == mmtc_pkg::MODE_CHECK)
						nxt.phase = mmtc_pkg::PH_CHECK;
					else
						nxt.phase = mmtc_pkg::PH_DOWN;
				end
			end
		end else if (st.phase != mmtc_pkg::PH_IDLE) begin
			run            = 1'b1;
			nxt.steps_done = step_sum[32] ? '1 : step_sum[31:0];
			nxt.elapsed_ms = ms_sum[32] ? '1 : ms_sum[31:0];
			if (st.window_ticks >= 5'(STALL_WINDOW)) begin
				nxt.window_ticks   = '0;
				en                 = (st.count_snapshot == nxt.steps_done);
				nxt.count_snapshot = nxt.steps_done;
			end else begin
				nxt.window_ticks = st.window_ticks + 5'd1;
			end
		end

		if (run) begin
			in_time = nxt.elapsed_ms < nxt.timeout_reg;
			case (nxt.phase)
				mmtc_pkg::PH_UP:
					keep = !cmd.top_switch && in_time &&
					       (nxt.active_mode == mmtc_pkg::MODE_HOME ||
					        nxt.target_reg == '0 || nxt.steps_done < nxt.target_reg);
				mmtc_pkg::PH_DOWN:
					keep = in_time && nxt.steps_done < nxt.target_reg;
				mmtc_pkg::PH_CHECK:
					keep = in_time && nxt.steps_done < nxt.target_reg && !cmd.check_switch;
				default:
					keep = 1'b1;
			endcase
			if (!keep) begin
				s = (nxt.phase == mmtc_pkg::PH_CHECK) ? !cmd.check_switch : !in_time;
				if (nxt.phase == mmtc_pkg::PH_UP && nxt.active_mode == mmtc_pkg::MODE_HOME &&
				    s == mmtc_pkg::ST_OK) begin
					// homed, start the down phase on the same transaction
					nxt.phase          = mmtc_pkg::PH_DOWN;
					nxt.steps_done     = '0;
					nxt.elapsed_ms     = '0;
					nxt.window_ticks   = '0;
					nxt.count_snapshot = '0;
					en                 = 1'b1;
					if (nxt.timeout_reg == '0 || nxt.target_reg == '0) begin
						nxt.phase = mmtc_pkg::PH_IDLE;
						done      = 1'b1;
						stv       = (nxt.timeout_reg == '0);
					end
				end else begin
					nxt.phase = mmtc_pkg::PH_IDLE;
					done      = 1'b1;
					stv       = s;
				end
			end
		end

		case (nxt.phase)
			mmtc_pkg::PH_IDLE: res.motor_dir = mmtc_pkg::DIR_BRAKE;
			mmtc_pkg::PH_UP:   res.motor_dir = mmtc_pkg::DIR_UP;
			default:           res.motor_dir = mmtc_pkg::DIR_DOWN;
		endcase
		res.pwm_speed     = nxt.speed_reg;
		res.driver_enable = en;
		res.done_res      = done;
		res.status        = done ? stv : mmtc_pkg::ST_OK;
		res.busy_res      = (nxt.phase != mmtc_pkg::PH_IDLE);
		res.step_count    = nxt.steps_done;
	end

endmodule

/* src/motor_move_timeout_controller.sv */
// motor move sequencer with step target, phase timeout and stall watchdog
// cmd channel: one transaction per timer tick or start command (cmd.req_type),
//   accepted at a clock edge with cmd_valid high and cmd_stall low
// res channel: exactly one result transaction per command transaction, in order,
//   accepted at a clock edge with res_valid high and res_stall low
// an accepted command waits in the input register until the result register is free,
//   then its result is registered there and offered on res
// throughput: one transaction per cycle while res_stall is low; the move state
//   is updated in the single pass from the input register to the result register
// when res_stall holds the result register, one more command is taken into the
//   input register and cmd_stall then rises until the result is taken
// reset (arst_n low) empties both registers and returns the move state to idle
//   with all counters and held settings cleared
// a tick while idle returns the idle status; a start while busy is ignored
module motor_move_timeout_controller #(
	parameter int unsigned TICK_MS      = mmtc_pkg::TICK_MS_DEF,
	parameter int unsigned STALL_WINDOW = mmtc_pkg::STALL_WINDOW_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  mmtc_pkg::cmd_t   cmd,
	output logic             res_valid,
	input  logic             res_stall,
	output mmtc_pkg::res_t   res
);

	logic              cmd_valid_s1;
	mmtc_pkg::cmd_t    cmd_s1;
	mmtc_pkg::mstate_t st_q;
	mmtc_pkg::mstate_t st_nxt;
	mmtc_pkg::res_t    res_d;
	logic              res_valid_q;
	mmtc_pkg::res_t    res_q;
	logic              out_free;
	logic              advance;

	assign out_free  = !res_valid_q || !res_stall;
	assign advance   = cmd_valid_s1 && out_free;
	assign cmd_stall = cmd_valid_s1 && !out_free;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	mmtc_step #(
		.TICK_MS      (TICK_MS),
		.STALL_WINDOW (STALL_WINDOW)
	) u_step (
		.st  (st_q),
		.cmd (cmd_s1),
		.nxt (st_nxt),
		.res (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			cmd_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			st_q        <= '{phase: mmtc_pkg::PH_IDLE, default: '0};
		end else begin
			if (out_free) begin
				res_valid_q <= cmd_valid_s1;
			end
			if (advance) begin
				st_q <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.done_res |-> !res.busy_res)
		else $error("finished move still reported busy");

	a_status_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status |-> res.done_res)
		else $error("timeout status without done");

	a_state_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(st_q))
		else $error("move state changed without a transaction");

	a_stall_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall && cmd_valid_s1 |-> cmd_stall)
		else $error("input taken while both registers are full");

endmodule

/* verif/motor_move_timeout_controller_tb.sv */
`timescale 1ns / 1ps

module motor_move_timeout_controller_tb;

	localparam int unsigned WATCHDOG_LIMIT = 4000;

	localparam int unsigned STALL_NONE   = 0;
	localparam int unsigned STALL_RANDOM = 1;
	localparam int unsigned STALL_TOGGLE = 2;
	localparam int unsigned STALL_HOLD   = 3;

	typedef struct {
		mmtc_pkg::cmd_t c;
		bit             drain;
	} queued_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	mmtc_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	mmtc_pkg::res_t res;

	queued_cmd_t pending_cmds[$];
	mmtc_pkg::res_t expected_results[$];
	mmtc_pkg::mstate_t motor = '0;

	int unsigned cmds_taken = 0;
	int unsigned results_taken = 0;
	int unsigned mismatches = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned stall_mode = STALL_NONE;
	int unsigned stall_left = 0;
	int unsigned idle_cycles = 0;

	motor_move_timeout_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #5 clk = ~clk;

	function automatic void restart_phase_counters();
		motor.steps_done     = '0;
		motor.elapsed_ms     = '0;
		motor.window_ticks   = '0;
		motor.count_snapshot = '0;
	endfunction

	function automatic bit phase_continues(input logic top, input logic chk);
		bit in_time;
		in_time = motor.elapsed_ms < motor.timeout_reg;
		case (motor.phase)
			mmtc_pkg::PH_UP: begin
				return !top && in_time && (motor.active_mode == mmtc_pkg::MODE_HOME ||
					motor.target_reg == 0 || motor.steps_done < motor.target_reg);
			end
			mmtc_pkg::PH_DOWN: begin
				return in_time && motor.steps_done < motor.target_reg;
			end
			default: begin
				return in_time && motor.steps_done < motor.target_reg && !chk;
			end
		endcase
	endfunction

	// end the phase at a switch, target or time limit, or send homing down
	function automatic void close_phase(input logic top, input logic chk,
		inout logic en, inout logic done, inout logic st);
		logic outcome;
		int pass;
		for (pass = 0; pass < 2; pass++) begin
			if (motor.phase == mmtc_pkg::PH_IDLE || phase_continues(top, chk))
				return;
			if (motor.phase == mmtc_pkg::PH_CHECK)
				outcome = chk ? mmtc_pkg::ST_OK : mmtc_pkg::ST_TIMEOUT;
			else
				outcome = (motor.elapsed_ms < motor.timeout_reg) ?
					mmtc_pkg::ST_OK : mmtc_pkg::ST_TIMEOUT;
			if (motor.phase == mmtc_pkg::PH_UP && motor.active_mode == mmtc_pkg::MODE_HOME &&
			    outcome == mmtc_pkg::ST_OK) begin
				restart_phase_counters();
				motor.phase = mmtc_pkg::PH_DOWN;
				en = 1'b1;
				continue;
			end
			motor.phase = mmtc_pkg::PH_IDLE;
			done = 1'b1;
			st = outcome;
			break;
		end
	endfunction

	function automatic mmtc_pkg::res_t predict_motor_result(input mmtc_pkg::cmd_t c);
		logic en;
		logic done;
		logic st;
		logic [32:0] sum;
		mmtc_pkg::res_t r;
		en = 1'b0;
		done = 1'b0;
		st = mmtc_pkg::ST_OK;
		if (c.req_type == mmtc_pkg::REQ_START) begin
			if (motor.phase == mmtc_pkg::PH_IDLE) begin
				motor.active_mode = c.move_mode;
				motor.target_reg = c.target_steps;
				motor.timeout_reg = c.timeout_ms;
				if (c.move_mode == mmtc_pkg::MODE_UP && c.top_switch) begin
					done = 1'b1;
				end else begin
					motor.speed_reg = c.speed;
					restart_phase_counters();
					en = 1'b1;
					if (c.move_mode == mmtc_pkg::MODE_UP ||
					    (c.move_mode == mmtc_pkg::MODE_HOME && !c.top_switch))
						motor.phase = mmtc_pkg::PH_UP;
					else if (c.move_mode == mmtc_pkg::MODE_CHECK)
						motor.phase = mmtc_pkg::PH_CHECK;
					else
						motor.phase = mmtc_pkg::PH_DOWN;
					close_phase(c.top_switch, c.check_switch, en, done, st);
				end
			end
		end else if (motor.phase != mmtc_pkg::PH_IDLE) begin
			sum = {1'b0, motor.steps_done} + 33'(c.encoder_pulses);
			motor.steps_done = sum[32] ? '1 : sum[31:0];
			sum = {1'b0, motor.elapsed_ms} + 33'(mmtc_pkg::TICK_MS_DEF);
			motor.elapsed_ms = sum[32] ? '1 : sum[31:0];
			if (motor.window_ticks >= 5'(mmtc_pkg::STALL_WINDOW_DEF)) begin
				motor.window_ticks = '0;
				if (motor.count_snapshot == motor.steps_done)
					en = 1'b1;
				motor.count_snapshot = motor.steps_done;
			end else begin
				motor.window_ticks = motor.window_ticks + 5'd1;
			end
			close_phase(c.top_switch, c.check_switch, en, done, st);
		end
		r.motor_dir = (motor.phase == mmtc_pkg::PH_UP) ? mmtc_pkg::DIR_UP :
			(motor.phase == mmtc_pkg::PH_IDLE) ? mmtc_pkg::DIR_BRAKE : mmtc_pkg::DIR_DOWN;
		r.pwm_speed = motor.speed_reg;
		r.driver_enable = en;
		r.done_res = done;
		r.status = done ? st : mmtc_pkg::ST_OK;
		r.busy_res = (motor.phase != mmtc_pkg::PH_IDLE);
		r.step_count = motor.steps_done;
		return r;
	endfunction

	function automatic mmtc_pkg::cmd_t start_cmd(input logic [1:0] mode,
		input logic [15:0] spd, input logic [31:0] target, input logic [31:0] limit_ms,
		input logic top, input logic chk);
		mmtc_pkg::cmd_t c;
		c.req_type = mmtc_pkg::REQ_START;
		c.move_mode = mode;
		c.speed = spd;
		c.target_steps = target;
		c.timeout_ms = limit_ms;
		c.top_switch = top;
		c.check_switch = chk;
		c.encoder_pulses = 8'($urandom);
		return c;
	endfunction

	function automatic mmtc_pkg::cmd_t tick_cmd(input logic top, input logic chk,
		input logic [7:0] pulses);
		mmtc_pkg::cmd_t c;
		c.req_type = mmtc_pkg::REQ_TICK;
		c.move_mode = 2'($urandom);
		c.speed = 16'($urandom);
		c.target_steps = $urandom;
		c.timeout_ms = $urandom;
		c.top_switch = top;
		c.check_switch = chk;
		c.encoder_pulses = pulses;
		return c;
	endfunction

	task automatic enqueue(input mmtc_pkg::cmd_t c, input bit drain = 1'b0);
		queued_cmd_t q;
		q.c = c;
		q.drain = drain;
		pending_cmds.push_back(q);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s expected %0d got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// command driver with bursts, gaps and an occasional full drain
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			cmds_taken <= 0;
			burst_left <= 0;
			gap_left <= 0;
			motor = '0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				expected_results.push_back(predict_motor_result(cmd));
				cmds_taken <= cmds_taken + 1;
			end
			if (!cmd_valid || !cmd_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					cmd_valid <= 1'b0;
				end else if (pending_cmds.size() == 0 || (pending_cmds[0].drain &&
						(cmd_valid || cmds_taken != results_taken))) begin
					cmd_valid <= 1'b0;
				end else begin
					cmd <= pending_cmds[0].c;
					cmd_valid <= 1'b1;
					pending_cmds.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// result monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			results_taken <= 0;
			stall_mode <= STALL_NONE;
			stall_left <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (results_taken >= cmds_taken) begin
					$error("result transaction with no command outstanding");
					mismatches++;
				end else begin
					check_field("motor_dir", expected_results[results_taken].motor_dir,
						res.motor_dir);
					check_field("pwm_speed", expected_results[results_taken].pwm_speed,
						res.pwm_speed);
					check_field("driver_enable", expected_results[results_taken].driver_enable,
						res.driver_enable);
					check_field("done_res", expected_results[results_taken].done_res,
						res.done_res);
					check_field("status", expected_results[results_taken].status, res.status);
					check_field("busy_res", expected_results[results_taken].busy_res,
						res.busy_res);
					check_field("step_count", expected_results[results_taken].step_count,
						res.step_count);
					results_taken <= results_taken + 1;
				end
			end
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(STALL_NONE, STALL_HOLD);
				stall_left <= $urandom_range(1, 30);
				res_stall <= 1'b0;
			end else begin
				stall_left <= stall_left - 1;
				case (stall_mode)
					STALL_NONE: res_stall <= 1'b0;
					STALL_RANDOM: res_stall <= ($urandom_range(0, 99) < 35);
					STALL_TOGGLE: res_stall <= ~res_stall;
					default: res_stall <= (stall_left > 4);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("motor_move_timeout_controller_tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [1:0] mode;
		logic [31:0] target;
		logic [31:0] limit_ms;
		int unsigned tick_span;
		int unsigned n_ticks;
		int unsigned pulse_style;
		int unsigned moves;
		int unsigned i;
		logic [7:0] pulses;

		// directed: idle tick, immediate ends, switch and timeout on one tick
		enqueue(tick_cmd(1'b1, 1'b1, 8'hFF));
		enqueue(start_cmd(mmtc_pkg::MODE_UP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b1, 1'b0));
		enqueue(start_cmd(mmtc_pkg::MODE_DOWN, 16'h4000, 32'd0, 32'd1000, 1'b0, 1'b0));
		enqueue(start_cmd(mmtc_pkg::MODE_DOWN, 16'h0001, 32'd5, 32'd0, 1'b0, 1'b1));
		enqueue(start_cmd(mmtc_pkg::MODE_UP, 16'hFFFF, 32'd0, 32'd40, 1'b0, 1'b0));
		enqueue(tick_cmd(1'b0, 1'b0, 8'd0));
		enqueue(tick_cmd(1'b1, 1'b0, 8'd3));
		// check move, with a start while busy
		enqueue(start_cmd(mmtc_pkg::MODE_CHECK, 16'h8000, 32'd100, 32'd1000, 1'b0, 1'b0));
		enqueue(start_cmd(mmtc_pkg::MODE_UP, 16'h1234, 32'd0, 32'd0, 1'b1, 1'b0));
		enqueue(tick_cmd(1'b0, 1'b0, 8'd10));
		enqueue(tick_cmd(1'b0, 1'b1, 8'd0));
		// homing into the down phase, and homing from the top
		enqueue(start_cmd(mmtc_pkg::MODE_HOME, 16'hC000, 32'd30, 32'd100, 1'b0, 1'b0));
		enqueue(tick_cmd(1'b1, 1'b0, 8'd5));
		enqueue(tick_cmd(1'b0, 1'b0, 8'd255));
		enqueue(start_cmd(mmtc_pkg::MODE_HOME, 16'h00FF, 32'd0, 32'd100, 1'b1, 1'b0));
		enqueue(start_cmd(mmtc_pkg::MODE_UP, 16'h7FFF, 32'd10, 32'hFFFF_FFFF, 1'b0, 1'b0));
		enqueue(tick_cmd(1'b0, 1'b0, 8'd255));
		enqueue(start_cmd(mmtc_pkg::MODE_CHECK, 16'h0000, 32'hFFFF_FFFF, 32'd20,
			1'b0, 1'b0));
		enqueue(tick_cmd(1'b0, 1'b0, 8'd0));
		enqueue(start_cmd(mmtc_pkg::MODE_HOME, 16'h5555, 32'd5, 32'd20, 1'b0, 1'b0));
		enqueue(tick_cmd(1'b0, 1'b0, 8'd0));
		enqueue(start_cmd(mmtc_pkg::MODE_CHECK, 16'hAAAA, 32'd50, 32'd500, 1'b0, 1'b1));

		moves = 0;
		while (pending_cmds.size() < 620) begin
			if ($urandom_range(0, 99) < 8) begin
				if ($urandom_range(0, 1) == 0)
					enqueue(tick_cmd(1'($urandom), 1'($urandom), 8'($urandom)));
				else
					enqueue(start_cmd(2'($urandom), 16'($urandom), $urandom, $urandom,
						1'($urandom), 1'($urandom)));
				continue;
			end
			mode = 2'($urandom_range(0, 3));
			case ($urandom_range(0, 9))
				0: target = 32'd0;
				1: target = $urandom;
				2: target = 32'hFFFF_FFFF;
				default: target = $urandom_range(1, 300);
			endcase
			case ($urandom_range(0, 9))
				0: limit_ms = 32'd0;
				1: limit_ms = (target > 300) ? $urandom_range(0, 1500) : $urandom;
				2: limit_ms = (target > 300) ? 32'd1500 : 32'hFFFF_FFFF;
				3, 4, 5: limit_ms = $urandom_range(1, 300);
				default: limit_ms = $urandom_range(300, 1500);
			endcase
			enqueue(start_cmd(mode, 16'($urandom), target, limit_ms,
				$urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0), moves % 40 == 0);
			moves++;
			tick_span = (limit_ms > 1600) ? 80 : limit_ms / 20 + 2;
			n_ticks = $urandom_range(1, tick_span);
			pulse_style = $urandom_range(0, 3);
			for (i = 0; i < n_ticks; i++) begin
				case (pulse_style)
					0: pulses = ($urandom_range(0, 9) != 0) ? 8'd0 : 8'($urandom_range(0, 3));
					1: pulses = 8'($urandom_range(0, 12));
					2: pulses = 8'($urandom);
					default: pulses = ($urandom_range(0, 1) == 0) ? 8'd0 :
						8'($urandom_range(0, 40));
				endcase
				enqueue(tick_cmd($urandom_range(0, 29) == 0, $urandom_range(0, 24) == 0,
					pulses));
				if ($urandom_range(0, 39) == 0)
					enqueue(start_cmd(2'($urandom), 16'($urandom), $urandom, $urandom,
						1'($urandom), 1'($urandom)));
			end
			// try to wind the move up so the next start is less likely lost
			n_ticks = $urandom_range(1, 3);
			for (i = 0; i < n_ticks; i++)
				enqueue(tick_cmd(1'b1, 1'b1, 8'd255));
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_cmds.size() != 0 || cmd_valid || cmds_taken != results_taken)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("motor_move_timeout_controller_tb OK");
		else
			$display("motor_move_timeout_controller_tb NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
src/mmtc_pkg.sv
src/mmtc_step.sv
src/motor_move_timeout_controller.sv
verif/motor_move_timeout_controller_tb.sv
